>>> rtl/core/rfp_pkg.sv
package rfp_pkg;

  // frame marker bytes
  localparam logic [7:0] HEAD_0 = 8'h53;
  localparam logic [7:0] HEAD_1 = 8'h59;
  localparam logic [7:0] FOOT_0 = 8'h54;
  localparam logic [7:0] FOOT_1 = 8'h43;

  // reset value of the maximum data length register
  localparam logic [15:0] MAX_LEN_RESET = 16'd64;

  // result status codes
  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_BAD_FOOTER = 3'd4;

  // one result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  control_code;
    logic [7:0]  command_code;
    logic [15:0] data_length;
    logic [7:0]  checksum_byte;
    logic        data_valid;
    logic [15:0] data_index;
    logic [7:0]  data_byte;
  } rfp_result_t;

endpackage

>>> rtl/core/rfp_in_if.sv
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/rfp_out_if.sv
interface rfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  control_code;
  logic [7:0]  command_code;
  logic [15:0] data_length;
  logic [7:0]  checksum_byte;
  logic        data_valid;
  logic [15:0] data_index;
  logic [7:0]  data_byte;

  modport source (
    output valid, output status, output control_code, output command_code,
    output data_length, output checksum_byte, output data_valid,
    output data_index, output data_byte, input ready
  );
  modport sink (
    input valid, input status, input control_code, input command_code,
    input data_length, input checksum_byte, input data_valid,
    input data_index, input data_byte, output ready
  );
endinterface

>>> rtl/core/rfp_parse.sv
module rfp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         max_len,
  output rfp_pkg::rfp_result_t result
);
  import rfp_pkg::*;

  // frame phases
  localparam logic [3:0] PH_HEAD0 = 4'd0;
  localparam logic [3:0] PH_HEAD1 = 4'd1;
  localparam logic [3:0] PH_CTRL  = 4'd2;
  localparam logic [3:0] PH_CMD   = 4'd3;
  localparam logic [3:0] PH_LENH  = 4'd4;
  localparam logic [3:0] PH_LENL  = 4'd5;
  localparam logic [3:0] PH_DATA  = 4'd6;
  localparam logic [3:0] PH_CSUM  = 4'd7;
  localparam logic [3:0] PH_FOOT0 = 4'd8;
  localparam logic [3:0] PH_FOOT1 = 4'd9;

  logic [3:0]  phase, phase_next;
  logic [15:0] data_cnt, data_cnt_next;
  logic [7:0]  held_control, held_control_next;
  logic [7:0]  held_command, held_command_next;
  logic [15:0] held_length, held_length_next;
  logic [7:0]  held_checksum, held_checksum_next;
  logic [2:0]  status;
  logic        dvalid;
  logic [15:0] len_low;

  assign len_low = {held_length[15:8], rx_byte};

  // per-byte phase decode
  always_comb begin
    phase_next         = phase;
    data_cnt_next      = data_cnt;
    held_control_next  = held_control;
    held_command_next  = held_command;
    held_length_next   = held_length;
    held_checksum_next = held_checksum;
    status             = ST_BUSY;
    dvalid             = 1'b0;
    unique case (phase)
      PH_HEAD0: begin
        if (rx_byte != HEAD_0) begin
          status = ST_BAD_HEADER;
        end else begin
          phase_next = PH_HEAD1;
        end
      end
      PH_HEAD1: begin
        if (rx_byte != HEAD_1) begin
          status     = ST_BAD_HEADER;
          phase_next = PH_HEAD0;
        end else begin
          phase_next = PH_CTRL;
        end
      end
      PH_CTRL: begin
        held_control_next = rx_byte;
        phase_next        = PH_CMD;
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        phase_next        = PH_LENH;
      end
      PH_LENH: begin
        held_length_next = {rx_byte, 8'h00};
        phase_next       = PH_LENL;
      end
      PH_LENL: begin
        held_length_next = len_low;
        data_cnt_next    = '0;
        if (len_low == 16'd0 || len_low > max_len) begin
          status     = ST_BAD_LENGTH;
          phase_next = PH_HEAD0;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        dvalid        = 1'b1;
        data_cnt_next = data_cnt + 16'd1;
        if (data_cnt == held_length - 16'd1) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        held_checksum_next = rx_byte;
        phase_next         = PH_FOOT0;
      end
      PH_FOOT0: begin
        if (rx_byte != FOOT_0) begin
          status     = ST_BAD_FOOTER;
          phase_next = PH_HEAD0;
        end else begin
          phase_next = PH_FOOT1;
        end
      end
      PH_FOOT1: begin
        status     = (rx_byte == FOOT_1) ? ST_DONE : ST_BAD_FOOTER;
        phase_next = PH_HEAD0;
      end
      default: begin
        phase_next = PH_HEAD0;
      end
    endcase
  end

  // result reports the held fields after this byte
  always_comb begin
    result.status        = status;
    result.control_code  = held_control_next;
    result.command_code  = held_command_next;
    result.data_length   = held_length_next;
    result.checksum_byte = held_checksum_next;
    result.data_valid    = dvalid;
    result.data_index    = dvalid ? data_cnt : 16'd0;
    result.data_byte     = dvalid ? rx_byte : 8'd0;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD0;
      data_cnt      <= '0;
      held_control  <= '0;
      held_command  <= '0;
      held_length   <= '0;
      held_checksum <= '0;
    end else if (step) begin
      phase         <= phase_next;
      data_cnt      <= data_cnt_next;
      held_control  <= held_control_next;
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      held_checksum <= held_checksum_next;
    end
  end

endmodule

>>> rtl/core/radar_frame_parser.sv
// radar_frame_parser: deframes sensor frames from a serial byte stream.
// rx takes one received byte per beat; res gives one result beat per byte
// with the status (in progress, frame complete, bad header, bad length,
// bad footer), the held control, command, length and checksum fields,
// and the byte itself with its index when it is a frame data byte.
// cfg_we/cfg_wdata write the maximum accepted data length (reset 64);
// write it only while no byte is in flight.
// A byte taken into the input register goes through the phase decode into the
// result register, which drives res. Throughput: one byte per cycle unless res
// stalls, set by the input and result registers around the phase decode.
// Reset clears the frame phase, the held fields, both stage valids and
// restores the maximum length; the block accepts bytes right after reset.
// When res stalls, the result register holds and an empty input register still
// takes one more byte; after that rx.ready drops until res moves again.
module radar_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  rfp_in_if.sink      rx,
  rfp_out_if.source   res
);
  import rfp_pkg::*;

  logic        max_len_we;
  logic [15:0] max_len;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        advance;
  logic        step;
  rfp_result_t result;
  rfp_result_t out_res;

  assign max_len_we = cfg_we;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (max_len_we) begin
      max_len <= cfg_wdata;
    end
  end

  // stage handshakes
  assign advance  = !out_valid || res.ready;
  assign step     = in_valid && advance;
  assign rx.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  rfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .max_len (max_len),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign res.valid         = out_valid;
  assign res.status        = out_res.status;
  assign res.control_code  = out_res.control_code;
  assign res.command_code  = out_res.command_code;
  assign res.data_length   = out_res.data_length;
  assign res.checksum_byte = out_res.checksum_byte;
  assign res.data_valid    = out_res.data_valid;
  assign res.data_index    = out_res.data_index;
  assign res.data_byte     = out_res.data_byte;

endmodule
